[rtl/core/tce_pkg.sv]
// ----------------------------------------------------------------------------
// tce_pkg
// Shared constants, widths and codes of the text console engine.
// ----------------------------------------------------------------------------
package tce_pkg;

  // screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;
  localparam int CELLS     = ROWS * COLUMNS;

  // derived widths
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int COLX_W = $clog2(COLUMNS + TAB_WIDTH);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ROWX_W = $clog2(ROWS + 1);
  localparam int PH_W   = $clog2(TAB_WIDTH);

  // field widths of the channels
  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int OCOL_W   = 7;
  localparam int OROW_W   = 5;
  localparam int OLOC_W   = 11;
  localparam int CELL_W   = 16;
  localparam int ATTR_W   = 8;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_TEXT_ATTR = 1'b0;

  // cell values
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, BLANK_CHAR};

  // character codes
  localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_ERASE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

endpackage

[rtl/core/tce_in_if.sv]
// ----------------------------------------------------------------------------
// tce_in_if
// Command channel of the text console engine: valid/ready plus one command.
// ----------------------------------------------------------------------------
interface tce_in_if;
  logic                          valid;
  logic                          ready;
  logic [tce_pkg::CMD_W-1:0]     cmd;
  logic [tce_pkg::CHAR_W-1:0]    char_code;
  logic [tce_pkg::INDEX_W-1:0]   cell_index;

  modport source (output valid, output cmd, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input cmd, input char_code, input cell_index,
                  output ready);
endinterface

[rtl/core/tce_out_if.sv]
// ----------------------------------------------------------------------------
// tce_out_if
// Result channel of the text console engine: cursor report and cell data.
// ----------------------------------------------------------------------------
interface tce_out_if;
  logic                         valid;
  logic                         ready;
  logic [tce_pkg::OCOL_W-1:0]   cursor_column;
  logic [tce_pkg::OROW_W-1:0]   cursor_row;
  logic [tce_pkg::OLOC_W-1:0]   cursor_location;
  logic [tce_pkg::CELL_W-1:0]   read_data;

  modport source (output valid, output cursor_column, output cursor_row,
                  output cursor_location, output read_data, input ready);
  modport sink   (input valid, input cursor_column, input cursor_row,
                  input cursor_location, input read_data, output ready);
endinterface

[rtl/core/text_console_engine_top.sv]
// ----------------------------------------------------------------------------
// text_console_engine_top
// Text-mode terminal: cell buffer in a single-port-write memory, cursor
// tracking and a sweep sequencer for scroll, clear and the reset fill.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          word
//  in_chan   in   valid/ready        cmd, char_code, cell_index
//  out_chan  out  valid/ready        cursor_column, cursor_row, cursor_location,
//                                    read_data
//  apb       in   psel/penable/pwrite text_attribute at byte address 0
//
// scroll: one cell copied or blanked per cycle through the one memory write port;
// clear screen blanks all ROWS*COLUMNS cells.
// after reset a fill pass writes all ROWS*COLUMNS cells, one per cycle, and
// in_chan.ready stays low meanwhile; configuration writes are taken at all times.
// a result waits in the output register; the sequencer holds its last step until
// the output register is free, and in_chan.ready is high only while idle.
// ----------------------------------------------------------------------------
module text_console_engine_top (
  input  logic                          clk,
  input  logic                          rst_n,
  tce_in_if.sink                        in_chan,
  tce_out_if.source                     out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tce_pkg::PADDR_W-1:0]   paddr,
  input  logic [tce_pkg::PDATA_W-1:0]   pwdata,
  output logic [tce_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  typedef enum logic [6:0] {
    ST_INIT  = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_COPY  = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_FILL  = 7'b0010000,
    ST_READ  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  localparam logic [tce_pkg::ADDR_W-1:0] LAST_CELL =
    tce_pkg::ADDR_W'(tce_pkg::CELLS - 1);
  localparam logic [tce_pkg::ADDR_W-1:0] LAST_COPY =
    tce_pkg::ADDR_W'(tce_pkg::CELLS - tce_pkg::COLUMNS - 1);

  state_t                          state_r, state_nxt;
  logic [tce_pkg::ADDR_W-1:0]      ptr_r, ptr_nxt;
  logic                            wr_v_r, wr_v_nxt;
  logic [tce_pkg::COL_W-1:0]       col_r, col_nxt;
  logic [tce_pkg::ROW_W-1:0]       row_r, row_nxt;
  logic [tce_pkg::PH_W-1:0]        phase_r, phase_nxt;
  logic [tce_pkg::ATTR_W-1:0]      attr_r;
  logic                            idx_ok_r, idx_ok_nxt;
  logic [tce_pkg::CELL_W-1:0]      data_r, data_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [tce_pkg::OCOL_W-1:0]      out_col_r;
  logic [tce_pkg::OROW_W-1:0]      out_row_r;
  logic [tce_pkg::OLOC_W-1:0]      out_loc_r;
  logic [tce_pkg::CELL_W-1:0]      out_data_r;

  logic [tce_pkg::CELL_W-1:0]      mem [tce_pkg::CELLS];
  logic [tce_pkg::CELL_W-1:0]      rdata_r;
  logic                            mem_we;
  logic [tce_pkg::ADDR_W-1:0]      mem_waddr;
  logic [tce_pkg::CELL_W-1:0]      mem_wdata;
  logic [tce_pkg::ADDR_W-1:0]      mem_raddr;

  logic                            accept;
  logic                            out_load;
  logic [tce_pkg::ADDR_W-1:0]      loc;
  logic [tce_pkg::CELL_W-1:0]      blank;
  logic                            printable;

  // cursor after a put character
  logic [tce_pkg::COLX_W-1:0]      pc_colx;
  logic [tce_pkg::ROWX_W-1:0]      pc_rowx;
  logic [tce_pkg::PH_W-1:0]        pc_phase;
  logic [tce_pkg::PH_W-1:0]        phase_dec;
  logic                            pc_scroll;

  assign accept   = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);
  assign loc      = tce_pkg::ADDR_W'(row_r) * tce_pkg::ADDR_W'(tce_pkg::COLUMNS)
                  + tce_pkg::ADDR_W'(col_r);
  assign blank    = {attr_r, tce_pkg::BLANK_CHAR};
  assign printable = (in_chan.char_code >= tce_pkg::CH_PRINT_LO) &&
                     (in_chan.char_code <= tce_pkg::CH_PRINT_HI);
  assign phase_dec = (phase_r == '0) ? tce_pkg::PH_W'(tce_pkg::TAB_WIDTH - 1)
                                     : phase_r - 1'b1;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[tce_pkg::PADDR_W-1:2] == tce_pkg::REG_TEXT_ATTR)
                ? tce_pkg::PDATA_W'(attr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tce_pkg::RESET_ATTR;
    end else if (psel && penable && pwrite && pready &&
                 paddr[tce_pkg::PADDR_W-1:2] == tce_pkg::REG_TEXT_ATTR) begin
      attr_r <= pwdata[tce_pkg::ATTR_W-1:0];
    end
  end

  // put character cursor step, then wrap and scroll check
  always_comb begin
    pc_colx  = tce_pkg::COLX_W'(col_r);
    pc_rowx  = tce_pkg::ROWX_W'(row_r);
    pc_phase = phase_r;
    priority if (in_chan.char_code == tce_pkg::CH_BS) begin
      if (col_r != '0) begin
        pc_colx  = tce_pkg::COLX_W'(col_r) - 1'b1;
        pc_phase = phase_dec;
      end
    end else if (in_chan.char_code == tce_pkg::CH_TAB) begin
      pc_colx  = tce_pkg::COLX_W'(col_r) + tce_pkg::COLX_W'(tce_pkg::TAB_WIDTH)
               - tce_pkg::COLX_W'(phase_r);
      pc_phase = '0;
    end else if (in_chan.char_code == tce_pkg::CH_CR) begin
      pc_colx  = '0;
      pc_phase = '0;
    end else if (in_chan.char_code == tce_pkg::CH_LF) begin
      pc_colx  = '0;
      pc_phase = '0;
      pc_rowx  = tce_pkg::ROWX_W'(row_r) + 1'b1;
    end else if (printable) begin
      pc_colx  = tce_pkg::COLX_W'(col_r) + 1'b1;
      pc_phase = (phase_r == tce_pkg::PH_W'(tce_pkg::TAB_WIDTH - 1)) ? '0
               : phase_r + 1'b1;
    end else begin
      pc_colx = tce_pkg::COLX_W'(col_r);
    end
    if (pc_colx >= tce_pkg::COLX_W'(tce_pkg::COLUMNS)) begin
      pc_colx  = '0;
      pc_phase = '0;
      pc_rowx  = pc_rowx + 1'b1;
    end
    pc_scroll = (pc_rowx >= tce_pkg::ROWX_W'(tce_pkg::ROWS));
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_r;
    mem_wdata = blank;
    mem_raddr = ptr_r + tce_pkg::ADDR_W'(tce_pkg::COLUMNS);
    unique case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = tce_pkg::RESET_CELL;
      end
      ST_FILL: begin
        mem_we = 1'b1;
      end
      ST_COPY, ST_DRAIN: begin
        mem_we    = wr_v_r || (state_r == ST_DRAIN);
        mem_waddr = ptr_r - 1'b1;
        mem_wdata = rdata_r;
      end
      ST_IDLE: begin
        mem_raddr = tce_pkg::ADDR_W'(in_chan.cell_index);
        if (accept && in_chan.cmd == tce_pkg::CMD_PUT && printable) begin
          mem_we    = 1'b1;
          mem_waddr = loc;
          mem_wdata = {attr_r, in_chan.char_code};
        end else if (accept && in_chan.cmd == tce_pkg::CMD_ERASE && col_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = loc - 1'b1;
        end
      end
      ST_READ, ST_DONE: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    wr_v_nxt      = wr_v_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    phase_nxt     = phase_r;
    idx_ok_nxt    = idx_ok_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_INIT: begin
        if (ptr_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          data_nxt  = '0;
          state_nxt = ST_DONE;
          unique case (tce_pkg::cmd_t'(in_chan.cmd))
            tce_pkg::CMD_PUT: begin
              col_nxt   = tce_pkg::COL_W'(pc_colx);
              phase_nxt = pc_phase;
              if (pc_scroll) begin
                row_nxt   = tce_pkg::ROW_W'(tce_pkg::ROWS - 1);
                ptr_nxt   = '0;
                wr_v_nxt  = 1'b0;
                state_nxt = ST_COPY;
              end else begin
                row_nxt = tce_pkg::ROW_W'(pc_rowx);
              end
            end
            tce_pkg::CMD_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              phase_nxt = '0;
              ptr_nxt   = '0;
              state_nxt = ST_FILL;
            end
            tce_pkg::CMD_ERASE: begin
              if (col_r != '0) begin
                col_nxt   = col_r - 1'b1;
                phase_nxt = phase_dec;
              end
            end
            tce_pkg::CMD_READ: begin
              idx_ok_nxt = (in_chan.cell_index < tce_pkg::INDEX_W'(tce_pkg::CELLS));
              state_nxt  = ST_READ;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_COPY: begin
        // read issued at ptr + COLUMNS, written back at ptr in the next cycle
        wr_v_nxt = 1'b1;
        ptr_nxt  = ptr_r + 1'b1;
        if (ptr_r == LAST_COPY) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        wr_v_nxt  = 1'b0;
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (ptr_r == LAST_CELL) begin
          state_nxt = ST_DONE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      ST_READ: begin
        data_nxt  = idx_ok_r ? rdata_r : '0;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      ptr_r       <= '0;
      wr_v_r      <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      phase_r     <= '0;
      idx_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      wr_v_r      <= wr_v_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      phase_r     <= phase_nxt;
      idx_ok_r    <= idx_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (out_load) begin
      out_col_r  <= tce_pkg::OCOL_W'(col_r);
      out_row_r  <= tce_pkg::OROW_W'(row_r);
      out_loc_r  <= tce_pkg::OLOC_W'(loc);
      out_data_r <= data_r;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.cursor_column   = out_col_r;
  assign out_chan.cursor_row      = out_row_r;
  assign out_chan.cursor_location = out_loc_r;
  assign out_chan.read_data       = out_data_r;

  // checks
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r < tce_pkg::COL_W'(tce_pkg::COLUMNS)) &&
    (row_r < tce_pkg::ROW_W'(tce_pkg::ROWS)))
    else $error("cursor out of screen");

  a_tab_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r == '0) |-> (phase_r == '0))
    else $error("tab phase out of step with column");

  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY || state_r == ST_DRAIN) |->
    (row_r == tce_pkg::ROW_W'(tce_pkg::ROWS - 1)))
    else $error("scroll with cursor off the last row");

  a_copy_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_v_r |-> (state_r == ST_COPY || state_r == ST_DRAIN))
    else $error("copy write pending outside scroll");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_chan.ready) |=>
    (state_r == ST_DONE && out_valid_r))
    else $error("result dropped while output register full");

endmodule
